### hdl/cbcr_pkg.sv
// Shared widths, axis record type and output saturation for the circle/box collision core.
package cbcr_pkg;

   // Coordinate width of the position, offset and box port fields
   localparam int CW   = 24;
   // Radius field width (unsigned)
   localparam int RW   = CW - 1;
   // Half extent at double scale (hi - lo)
   localparam int HW   = CW + 1;
   // Box centre at double scale (lo + hi + 2*pos)
   localparam int CCW  = CW + 3;
   // Circle centre at double scale (2*(pos + offset))
   localparam int QW   = CW + 2;
   // Centre vector q - c
   localparam int DW   = CW + 4;
   // Clamp error (clamped - d)
   localparam int EW   = CW + 5;
   // Squared error, distance sum, penetration products, squared radius
   localparam int SQW  = 2 * EW;
   localparam int DSW  = SQW + 1;
   localparam int PW   = DW + HW;
   localparam int RADW = 2 * CW;
   // Corrected centre before halving
   localparam int FW   = CW + 4;

   // Per-axis record leaving the front end
   typedef struct packed {
      logic signed [CCW-1:0] c;
      logic signed [HW-1:0]  h;
      logic signed [QW-1:0]  q;
      logic                  d_pos;
      logic                  d_neg;
      logic [DW-1:0]         d_mag;
      logic [HW-1:0]         h_mag;
      logic [EW-1:0]         e_mag;
   } axis_type;

   // Clip a wide signed value to the coordinate range
   function automatic logic signed [CW-1:0] sat_coord(input logic signed [FW-1:0] v);
      logic                 all_zero;
      logic                 all_one;
      logic signed [CW-1:0] r;
      all_zero = ~|v[FW-1:CW-1];
      all_one  = &v[FW-1:CW-1];
      if (all_zero || all_one) begin
         r = v[CW-1:0];
      end else if (v[FW-1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### hdl/cbcr_axis.sv
// Three-stage per-axis front end: box centre, half extent, centre vector and clamp error.
module cbcr_axis (
   input  logic                             clock,
   input  logic signed [cbcr_pkg::CW-1:0]   pos,
   input  logic signed [cbcr_pkg::CW-1:0]   off,
   input  logic signed [cbcr_pkg::CW-1:0]   box_pos,
   input  logic signed [cbcr_pkg::CW-1:0]   box_lo,
   input  logic signed [cbcr_pkg::CW-1:0]   box_hi,
   output cbcr_pkg::axis_type               axis_out
);

   // stage 1: centre, extent and circle centre, all at double scale
   logic signed [cbcr_pkg::HW-1:0]  h1_in,  h1_ff;
   logic signed [cbcr_pkg::CCW-1:0] c1_in,  c1_ff;
   logic signed [cbcr_pkg::QW-1:0]  q1_in,  q1_ff;

   always_comb begin
      h1_in = cbcr_pkg::HW'(box_hi) - cbcr_pkg::HW'(box_lo);
      c1_in = cbcr_pkg::CCW'(box_lo) + cbcr_pkg::CCW'(box_hi)
            + (cbcr_pkg::CCW'(box_pos) <<< 1);
      q1_in = (cbcr_pkg::QW'(pos) + cbcr_pkg::QW'(off)) <<< 1;
   end

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      c1_ff <= c1_in;
      q1_ff <= q1_in;
   end

   // stage 2: vector from box centre to circle centre
   logic signed [cbcr_pkg::DW-1:0]  d2_in, d2_ff;
   logic signed [cbcr_pkg::HW-1:0]  h2_ff;
   logic signed [cbcr_pkg::CCW-1:0] c2_ff;
   logic signed [cbcr_pkg::QW-1:0]  q2_ff;

   assign d2_in = cbcr_pkg::DW'(q1_ff) - cbcr_pkg::DW'(c1_ff);

   always_ff @(posedge clock) begin
      d2_ff <= d2_in;
      h2_ff <= h1_ff;
      c2_ff <= c1_ff;
      q2_ff <= q1_ff;
   end

   // stage 3: clamp error magnitude, sign and magnitudes of d and h
   logic signed [cbcr_pkg::EW-1:0] hw;
   logic signed [cbcr_pkg::EW-1:0] dw;
   logic signed [cbcr_pkg::EW-1:0] e_lo;
   logic signed [cbcr_pkg::EW-1:0] e_hi;
   logic                           below;
   logic                           above;
   cbcr_pkg::axis_type             a3_in, a3_ff;

   always_comb begin
      hw    = cbcr_pkg::EW'(h2_ff);
      dw    = cbcr_pkg::EW'(d2_ff);
      below = dw < -hw;
      above = dw > hw;
      e_lo  = -hw - dw;
      e_hi  = dw - hw;
      a3_in.c     = c2_ff;
      a3_in.h     = h2_ff;
      a3_in.q     = q2_ff;
      a3_in.d_pos = (d2_ff > 0);
      a3_in.d_neg = d2_ff[cbcr_pkg::DW-1];
      a3_in.d_mag = d2_ff[cbcr_pkg::DW-1] ? cbcr_pkg::DW'(-d2_ff) : cbcr_pkg::DW'(d2_ff);
      a3_in.h_mag = h2_ff[cbcr_pkg::HW-1] ? cbcr_pkg::HW'(-h2_ff) : cbcr_pkg::HW'(h2_ff);
      // lower bound wins when an inverted box makes both true
      if (below) begin
         a3_in.e_mag = cbcr_pkg::EW'(e_lo);
      end else if (above) begin
         a3_in.e_mag = cbcr_pkg::EW'(e_hi);
      end else begin
         a3_in.e_mag = '0;
      end
   end

   always_ff @(posedge clock) begin
      a3_ff <= a3_in;
   end

   assign axis_out = a3_ff;

endmodule

### hdl/circle_box_collision_resolve_core.sv
// Top level: pipelined circle versus box overlap test with push-out position.
//
// Usage
//   Request channel: drive the req_ fields and raise start; the request is
//   taken at any rising edge where start is high and busy is low. busy is
//   only high while reset is asserted, so one request per cycle is taken.
//   Response channel: rsp_valid strobes for one cycle with rsp_hit and the
//   corrected position rsp_fixed_pos_x/y (zero when there is no hit).
//   The receiver cannot stall; every response appears exactly once.
// Timing
//   A request passes through six register stages: three front-end stages
//   per axis, one multiply stage (squares and penetration cross products),
//   one compare/select stage, and the output register with halving and
//   saturation. Throughput is one request per cycle.
// Reset
//   Synchronous, active high. All valid bits clear; requests in flight are
//   dropped. No configuration and no state between requests.
module circle_box_collision_resolve_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [cbcr_pkg::CW-1:0]  req_circle_pos_x,
   input  logic signed [cbcr_pkg::CW-1:0]  req_circle_pos_y,
   input  logic signed [cbcr_pkg::CW-1:0]  req_circle_offset_x,
   input  logic signed [cbcr_pkg::CW-1:0]  req_circle_offset_y,
   input  logic        [cbcr_pkg::RW-1:0]  req_circle_radius,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_pos_x,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_pos_y,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_lo_x,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_lo_y,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_hi_x,
   input  logic signed [cbcr_pkg::CW-1:0]  req_box_hi_y,
   output logic                            rsp_valid,
   output logic                            rsp_hit,
   output logic signed [cbcr_pkg::CW-1:0]  rsp_fixed_pos_x,
   output logic signed [cbcr_pkg::CW-1:0]  rsp_fixed_pos_y
);

   localparam int CW = cbcr_pkg::CW;

   // request taken
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // valid bits for stages 1..5
   logic [4:0] vld_in, vld_ff;
   assign vld_in = {vld_ff[3:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // side data carried alongside the front end
   logic signed [CW-1:0] ox_ff [5];
   logic signed [CW-1:0] oy_ff [5];
   logic        [CW-1:0] r2_ff [3];

   always_ff @(posedge clock) begin
      ox_ff[0] <= req_circle_offset_x;
      oy_ff[0] <= req_circle_offset_y;
      r2_ff[0] <= {req_circle_radius, 1'b0};
      for (int i = 1; i < 5; i++) begin
         ox_ff[i] <= ox_ff[i-1];
         oy_ff[i] <= oy_ff[i-1];
      end
      for (int i = 1; i < 3; i++) begin
         r2_ff[i] <= r2_ff[i-1];
      end
   end

   // per-axis front end, stages 1..3
   cbcr_pkg::axis_type ax3;
   cbcr_pkg::axis_type ay3;

   cbcr_axis u_axis_x (
      .clock    (clock),
      .pos      (req_circle_pos_x),
      .off      (req_circle_offset_x),
      .box_pos  (req_box_pos_x),
      .box_lo   (req_box_lo_x),
      .box_hi   (req_box_hi_x),
      .axis_out (ax3)
   );

   cbcr_axis u_axis_y (
      .clock    (clock),
      .pos      (req_circle_pos_y),
      .off      (req_circle_offset_y),
      .box_pos  (req_box_pos_y),
      .box_lo   (req_box_lo_y),
      .box_hi   (req_box_hi_y),
      .axis_out (ay3)
   );

   // stage 4: squared errors, squared radius, penetration cross products
   logic [cbcr_pkg::SQW-1:0]  sqx4_in, sqx4_ff;
   logic [cbcr_pkg::SQW-1:0]  sqy4_in, sqy4_ff;
   logic [cbcr_pkg::RADW-1:0] rad4_in, rad4_ff;
   logic [cbcr_pkg::PW-1:0]   penx4_in, penx4_ff;
   logic [cbcr_pkg::PW-1:0]   peny4_in, peny4_ff;
   cbcr_pkg::axis_type        ax4_ff, ay4_ff;
   logic [CW-1:0]             r2_4_ff;

   always_comb begin
      sqx4_in  = cbcr_pkg::SQW'(ax3.e_mag) * cbcr_pkg::SQW'(ax3.e_mag);
      sqy4_in  = cbcr_pkg::SQW'(ay3.e_mag) * cbcr_pkg::SQW'(ay3.e_mag);
      rad4_in  = cbcr_pkg::RADW'(r2_ff[2]) * cbcr_pkg::RADW'(r2_ff[2]);
      penx4_in = cbcr_pkg::PW'(ax3.d_mag) * cbcr_pkg::PW'(ay3.h_mag);
      peny4_in = cbcr_pkg::PW'(ay3.d_mag) * cbcr_pkg::PW'(ax3.h_mag);
   end

   always_ff @(posedge clock) begin
      sqx4_ff  <= sqx4_in;
      sqy4_ff  <= sqy4_in;
      rad4_ff  <= rad4_in;
      penx4_ff <= penx4_in;
      peny4_ff <= peny4_in;
      ax4_ff   <= ax3;
      ay4_ff   <= ay3;
      r2_4_ff  <= r2_ff[2];
   end

   // stage 5: overlap test and push-out centre at double scale
   logic [cbcr_pkg::DSW-1:0]       dist5;
   logic signed [cbcr_pkg::FW-1:0] r2s;
   logic signed [cbcr_pkg::FW-1:0] extx, exty;
   logic signed [cbcr_pkg::FW-1:0] fx5_in, fx5_ff;
   logic signed [cbcr_pkg::FW-1:0] fy5_in, fy5_ff;
   logic                           hit5_in, hit5_ff;

   always_comb begin
      dist5   = cbcr_pkg::DSW'(sqx4_ff) + cbcr_pkg::DSW'(sqy4_ff);
      hit5_in = dist5 < cbcr_pkg::DSW'(rad4_ff);
      r2s     = signed'(cbcr_pkg::FW'(r2_4_ff));
      extx    = cbcr_pkg::FW'(ax4_ff.h) + r2s;
      exty    = cbcr_pkg::FW'(ay4_ff.h) + r2s;
      // face plus radius along the sign of the centre vector; zero sign keeps centre
      if (ax4_ff.d_pos) begin
         fx5_in = cbcr_pkg::FW'(ax4_ff.c) + extx;
      end else if (ax4_ff.d_neg) begin
         fx5_in = cbcr_pkg::FW'(ax4_ff.c) - extx;
      end else begin
         fx5_in = cbcr_pkg::FW'(ax4_ff.c);
      end
      if (ay4_ff.d_pos) begin
         fy5_in = cbcr_pkg::FW'(ay4_ff.c) + exty;
      end else if (ay4_ff.d_neg) begin
         fy5_in = cbcr_pkg::FW'(ay4_ff.c) - exty;
      end else begin
         fy5_in = cbcr_pkg::FW'(ay4_ff.c);
      end
      // only the axis of greater relative penetration moves; both on a tie
      if (peny4_ff < penx4_ff) begin
         fy5_in = cbcr_pkg::FW'(ay4_ff.q);
      end else if (penx4_ff < peny4_ff) begin
         fx5_in = cbcr_pkg::FW'(ax4_ff.q);
      end
   end

   always_ff @(posedge clock) begin
      fx5_ff  <= fx5_in;
      fy5_ff  <= fy5_in;
      hit5_ff <= hit5_in;
   end

   // stage 6: halve (floor), back to collider position, saturate
   logic signed [cbcr_pkg::FW-1:0] posx6, posy6;
   logic signed [CW-1:0]           fpx_in, fpx_ff;
   logic signed [CW-1:0]           fpy_in, fpy_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff;

   always_comb begin
      posx6 = (fx5_ff >>> 1) - cbcr_pkg::FW'(ox_ff[4]);
      posy6 = (fy5_ff >>> 1) - cbcr_pkg::FW'(oy_ff[4]);
      if (hit5_ff) begin
         fpx_in = cbcr_pkg::sat_coord(posx6);
         fpy_in = cbcr_pkg::sat_coord(posy6);
      end else begin
         fpx_in = '0;
         fpy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= hit5_ff;
      fpx_ff     <= fpx_in;
      fpy_ff     <= fpy_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_fixed_pos_x = fpx_ff;
   assign rsp_fixed_pos_y = fpy_ff;

   // every response traces back to an accepted request
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("response without matching request");

   // a zero radius can never overlap
   a_hit_needs_radius : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> ($past(req_circle_radius, 6) != '0))
      else $error("hit reported for zero radius");

   // a miss carries a zero position
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_fixed_pos_x == '0 && rsp_fixed_pos_y == '0))
      else $error("miss with non-zero position");

endmodule

### tb/sv/circle_box_collision_resolve_core_tb.sv
// Self-checking testbench for the circle versus box collision resolve core.
`timescale 1ns / 100ps

module circle_box_collision_resolve_core_tb;

   localparam int CW             = cbcr_pkg::CW;
   localparam int RW             = cbcr_pkg::RW;
   localparam int PIPE_LATENCY   = 6;
   localparam int RANDOM_PAIRS   = 550;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int COORD_MAX      = 8388607;
   localparam int COORD_MIN      = -8388608;
   localparam int RADIUS_MAX     = 8388607;

   // One circle/box request, fields as on the ports
   typedef struct packed {
      logic signed [CW-1:0] circle_pos_x;
      logic signed [CW-1:0] circle_pos_y;
      logic signed [CW-1:0] circle_offset_x;
      logic signed [CW-1:0] circle_offset_y;
      logic        [RW-1:0] circle_radius;
      logic signed [CW-1:0] box_pos_x;
      logic signed [CW-1:0] box_pos_y;
      logic signed [CW-1:0] box_lo_x;
      logic signed [CW-1:0] box_lo_y;
      logic signed [CW-1:0] box_hi_x;
      logic signed [CW-1:0] box_hi_y;
   } pair_type;

   // One response: contact flag and corrected collider position
   typedef struct packed {
      logic                 hit;
      logic signed [CW-1:0] fixed_pos_x;
      logic signed [CW-1:0] fixed_pos_y;
   } contact_type;

   typedef struct {
      pair_type    req;
      bit          typed;
      contact_type want;
   } probe_row_type;

   localparam contact_type NO_CONTACT        = '{1'b0, 24'sd0, 24'sd0};
   localparam contact_type CONTACT_AT_ORIGIN = '{1'b1, 24'sd0, 24'sd0};

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic signed [CW-1:0] req_circle_pos_x;
   logic signed [CW-1:0] req_circle_pos_y;
   logic signed [CW-1:0] req_circle_offset_x;
   logic signed [CW-1:0] req_circle_offset_y;
   logic        [RW-1:0] req_circle_radius;
   logic signed [CW-1:0] req_box_pos_x;
   logic signed [CW-1:0] req_box_pos_y;
   logic signed [CW-1:0] req_box_lo_x;
   logic signed [CW-1:0] req_box_lo_y;
   logic signed [CW-1:0] req_box_hi_x;
   logic signed [CW-1:0] req_box_hi_y;
   logic                 rsp_valid;
   logic                 rsp_hit;
   logic signed [CW-1:0] rsp_fixed_pos_x;
   logic signed [CW-1:0] rsp_fixed_pos_y;

   contact_type   pending_contacts[$];
   probe_row_type probe_table[$];
   contact_type   oldest;
   int            errors;
   int            responses_checked;
   int            contacts_seen;
   int            idle_cycles;
   int            random_sent;

   circle_box_collision_resolve_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_circle_pos_x    (req_circle_pos_x),
      .req_circle_pos_y    (req_circle_pos_y),
      .req_circle_offset_x (req_circle_offset_x),
      .req_circle_offset_y (req_circle_offset_y),
      .req_circle_radius   (req_circle_radius),
      .req_box_pos_x       (req_box_pos_x),
      .req_box_pos_y       (req_box_pos_y),
      .req_box_lo_x        (req_box_lo_x),
      .req_box_lo_y        (req_box_lo_y),
      .req_box_hi_x        (req_box_hi_x),
      .req_box_hi_y        (req_box_hi_y),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_fixed_pos_x     (rsp_fixed_pos_x),
      .rsp_fixed_pos_y     (rsp_fixed_pos_y)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint sign_of(input longint v);
      return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
   endfunction

   // Clamp to half extent; an inverted box has negative h and clamps to -h first
   function automatic longint clamp_to_extent(input longint d, input longint h);
      if (d < -h) return -h;
      if (d > h) return h;
      return d;
   endfunction

   function automatic logic signed [CW-1:0] clip_coord(input longint v);
      if (v > COORD_MAX) return CW'(COORD_MAX);
      if (v < COORD_MIN) return CW'(COORD_MIN);
      return CW'(v);
   endfunction

   // Contact test and push-out, all at twice the coordinate scale
   function automatic contact_type resolve_contact(input pair_type p);
      longint hx, hy, cx, cy, qx, qy, dx, dy, ex, ey, r2;
      longint dist_sq, rad, pen_x, pen_y, fx, fy, sgx, sgy;
      contact_type c;
      hx = longint'(p.box_hi_x) - longint'(p.box_lo_x);
      hy = longint'(p.box_hi_y) - longint'(p.box_lo_y);
      cx = longint'(p.box_lo_x) + longint'(p.box_hi_x) + 2 * longint'(p.box_pos_x);
      cy = longint'(p.box_lo_y) + longint'(p.box_hi_y) + 2 * longint'(p.box_pos_y);
      qx = 2 * (longint'(p.circle_pos_x) + longint'(p.circle_offset_x));
      qy = 2 * (longint'(p.circle_pos_y) + longint'(p.circle_offset_y));
      r2 = 2 * longint'({1'b0, p.circle_radius});
      dx = qx - cx;
      dy = qy - cy;
      ex = clamp_to_extent(dx, hx) - dx;
      ey = clamp_to_extent(dy, hy) - dy;
      dist_sq = ex * ex + ey * ey;
      rad = r2 * r2;
      c = NO_CONTACT;
      if (dist_sq < rad) begin
         sgx = sign_of(dx);
         sgy = sign_of(dy);
         fx = cx + sgx * hx + sgx * r2;
         fy = cy + sgy * hy + sgy * r2;
         // axis of greater relative penetration, both on a tie
         pen_x = magnitude(dx) * magnitude(hy);
         pen_y = magnitude(dy) * magnitude(hx);
         if (pen_y < pen_x) fy = qy;
         else if (pen_x < pen_y) fx = qx;
         c.hit = 1'b1;
         // arithmetic shift halves towards minus infinity
         c.fixed_pos_x = clip_coord((fx >>> 1) - longint'(p.circle_offset_x));
         c.fixed_pos_y = clip_coord((fy >>> 1) - longint'(p.circle_offset_y));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic pair_type make_pair(input int px, input int py, input int ox,
                                          input int oy, input int r, input int bpx,
                                          input int bpy, input int lox, input int loy,
                                          input int hix, input int hiy);
      pair_type p;
      p.circle_pos_x    = CW'(px);
      p.circle_pos_y    = CW'(py);
      p.circle_offset_x = CW'(ox);
      p.circle_offset_y = CW'(oy);
      p.circle_radius   = RW'(r);
      p.box_pos_x       = CW'(bpx);
      p.box_pos_y       = CW'(bpy);
      p.box_lo_x        = CW'(lox);
      p.box_lo_y        = CW'(loy);
      p.box_hi_x        = CW'(hix);
      p.box_hi_y        = CW'(hiy);
      return p;
   endfunction

   function automatic void add_row(input pair_type p, input bit typed,
                                   input contact_type want);
      probe_table.push_back('{p, typed, want});
   endfunction

   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly pairs near contact, plus awkward boxes, edge-of-range and raw noise
   function automatic pair_type random_pair();
      int mode, sub, bpx, bpy, lox, loy, hix, hiy, tmp;
      int dxr, dyr, rad, ox, oy, ccx, ccy;
      pair_type p;
      mode = $urandom_range(0, 9);
      if (mode >= 7 && mode <= 8) begin
         p.circle_pos_x    = CW'($urandom);
         p.circle_pos_y    = CW'($urandom);
         p.circle_offset_x = CW'($urandom);
         p.circle_offset_y = CW'($urandom);
         p.circle_radius   = RW'($urandom);
         p.box_pos_x       = CW'($urandom);
         p.box_pos_y       = CW'($urandom);
         p.box_lo_x        = CW'($urandom);
         p.box_lo_y        = CW'($urandom);
         p.box_hi_x        = CW'($urandom);
         p.box_hi_y        = CW'($urandom);
         return p;
      end
      bpx = spread(1 << 20);
      bpy = spread(1 << 20);
      lox = -int'($urandom_range(0, 2048));
      loy = -int'($urandom_range(0, 2048));
      hix = int'($urandom_range(0, 2048));
      hiy = int'($urandom_range(0, 2048));
      dxr = spread(3000);
      dyr = spread(3000);
      rad = $urandom_range(0, 2500);
      ox  = spread(4096);
      oy  = spread(4096);
      if (mode == 6) begin
         sub = $urandom_range(0, 3);
         case (sub)
            0: begin
               tmp = lox; lox = hix; hix = tmp;
               if ($urandom_range(0, 1) == 1) begin
                  tmp = loy; loy = hiy; hiy = tmp;
               end
            end
            1: begin
               hix = lox;
               if ($urandom_range(0, 1) == 1) hiy = loy;
            end
            2: begin
               // square box with the circle on a diagonal: tied penetration
               loy = lox;
               hiy = hix;
               dyr = ($urandom_range(0, 1) == 1) ? dxr : -dxr;
            end
            default: begin
               // centre on an axis of the box
               if ($urandom_range(0, 1) == 1) dxr = 0; else dyr = 0;
            end
         endcase
      end else if (mode == 9) begin
         // boxes at the range edges with big radii to drive saturation
         bpx = ($urandom_range(0, 1) == 1) ? COORD_MAX - int'($urandom_range(0, 4000))
                                           : COORD_MIN + int'($urandom_range(0, 4000));
         bpy = ($urandom_range(0, 1) == 1) ? COORD_MAX - int'($urandom_range(0, 4000))
                                           : COORD_MIN + int'($urandom_range(0, 4000));
         rad = $urandom_range(0, RADIUS_MAX);
      end
      ccx = bpx + (lox + hix) / 2 + dxr;
      ccy = bpy + (loy + hiy) / 2 + dyr;
      return make_pair(ccx - ox, ccy - oy, ox, oy, rad, bpx, bpy, lox, loy, hix, hiy);
   endfunction

   task automatic present_pair(input pair_type p);
      req_circle_pos_x    <= p.circle_pos_x;
      req_circle_pos_y    <= p.circle_pos_y;
      req_circle_offset_x <= p.circle_offset_x;
      req_circle_offset_y <= p.circle_offset_y;
      req_circle_radius   <= p.circle_radius;
      req_box_pos_x       <= p.box_pos_x;
      req_box_pos_y       <= p.box_pos_y;
      req_box_lo_x        <= p.box_lo_x;
      req_box_lo_y        <= p.box_lo_y;
      req_box_hi_x        <= p.box_hi_x;
      req_box_hi_y        <= p.box_hi_y;
   endtask

   // Present one request and hold it until the accepting edge
   task automatic issue_pair(input pair_type p, input contact_type want);
      present_pair(p);
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_contacts.push_back(want);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (pending_contacts.size() == 0) begin
            $error("response with no request outstanding: hit %0d x %0d y %0d",
                   rsp_hit, rsp_fixed_pos_x, rsp_fixed_pos_y);
            errors++;
         end else begin
            oldest = pending_contacts.pop_front();
            responses_checked++;
            if (rsp_hit === 1'b1) contacts_seen++;
            if (rsp_hit !== oldest.hit) begin
               $error("rsp_hit: expected %0d, got %0d", oldest.hit, rsp_hit);
               errors++;
            end
            if (rsp_fixed_pos_x !== oldest.fixed_pos_x) begin
               $error("rsp_fixed_pos_x: expected %0d, got %0d",
                      oldest.fixed_pos_x, rsp_fixed_pos_x);
               errors++;
            end
            if (rsp_fixed_pos_y !== oldest.fixed_pos_y) begin
               $error("rsp_fixed_pos_y: expected %0d, got %0d",
                      oldest.fixed_pos_y, rsp_fixed_pos_y);
               errors++;
            end
         end
      end
   end

   // Watchdog: cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no progress for %0d cycles, %0d responses outstanding",
               idle_cycles, pending_contacts.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int       burst;
      pair_type rnd_pair;
      errors            = 0;
      responses_checked = 0;
      contacts_seen     = 0;
      idle_cycles       = 0;
      random_sent       = 0;
      reset <= 1'b1;
      start <= 1'b0;
      present_pair('0);

      // directed rows: typed where obvious, otherwise predicted
      add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NO_CONTACT);
      add_row(make_pair(COORD_MAX, COORD_MAX, 0, 0, 0, COORD_MIN, COORD_MIN, 0, 0, 0, 0),
              1'b1, NO_CONTACT);
      add_row(make_pair(0, 0, 0, 0, 256, 0, 0, -256, -256, 256, 256), 1'b1,
              CONTACT_AT_ORIGIN);
      add_row(make_pair(0, 0, 0, 0, RADIUS_MAX, 0, 0, 0, 0, 0, 0), 1'b1,
              CONTACT_AT_ORIGIN);
      // distance exactly equal to radius is not a contact
      add_row(make_pair(612, 0, 0, 0, 100, 0, 0, -512, -512, 512, 512), 1'b1, NO_CONTACT);
      add_row(make_pair(400, 100, 0, 0, 256, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(100, -400, 0, 0, 256, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(300, 300, 0, 0, 256, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(-300, 300, 0, 0, 256, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(0, 300, 0, 0, 256, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(600, 600, 0, 0, 200, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(700, 700, 0, 0, 100, 0, 0, -512, -512, 512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(300, 0, 0, 0, 256, 0, 0, 512, -512, -512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(300, -200, 0, 0, 256, 0, 0, 512, 512, -512, -512), 1'b0, NO_CONTACT);
      add_row(make_pair(0, 10, 0, 0, 256, 0, 0, 0, -512, 0, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(100, 50, 0, 0, 200, 0, 0, 0, 0, 0, 0), 1'b0, NO_CONTACT);
      // box centre on a half LSB
      add_row(make_pair(1, 1, 0, 0, 100, 0, 0, 0, 0, 3, 3), 1'b0, NO_CONTACT);
      add_row(make_pair(-3, -2, 0, 0, 100, -1, -1, 0, 0, 3, 1), 1'b0, NO_CONTACT);
      // push-out beyond the coordinate range
      add_row(make_pair(COORD_MAX - 100, 0, 0, 0, RADIUS_MAX, COORD_MAX, 0, -1024, -256,
                        -512, 256), 1'b0, NO_CONTACT);
      add_row(make_pair(COORD_MIN + 100, 0, 0, 0, RADIUS_MAX, COORD_MIN, 0, 512, -256,
                        1024, 256), 1'b0, NO_CONTACT);
      add_row(make_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 300, 0, 0, -512, -512,
                        512, 512), 1'b0, NO_CONTACT);
      add_row(make_pair(-1000, 2000, 1200, -1800, 256, 0, 0, -512, -512, 512, 512), 1'b0,
              NO_CONTACT);
      add_row(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 1'b0,
              NO_CONTACT);
      add_row(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 1'b0, NO_CONTACT);
      add_row(make_pair(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 23'h2AAAAA,
                        24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 24'h555555,
                        24'hAAAAAA), 1'b0, NO_CONTACT);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table, with the odd gap between rows
      foreach (probe_table[i]) begin
         issue_pair(probe_table[i].req,
                    probe_table[i].typed ? probe_table[i].want
                                         : resolve_contact(probe_table[i].req));
         if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 4));
      end

      // random part in bursts; one full drain half way through
      while (random_sent < RANDOM_PAIRS) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && random_sent < RANDOM_PAIRS; k++) begin
            rnd_pair = random_pair();
            issue_pair(rnd_pair, resolve_contact(rnd_pair));
            random_sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 9));
         if (random_sent >= RANDOM_PAIRS / 2 && random_sent - burst < RANDOM_PAIRS / 2) begin
            start <= 1'b0;
            while (pending_contacts.size() != 0) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Covered %0d directed rows and %0d random circle/box requests in bursts",
               probe_table.size(), random_sent);
      $display("%0d responses checked, %0d reported contact", responses_checked,
               contacts_seen);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
